// ===== hdl/uoi_pkg.sv =====
// Shared constants, types and the quarter-wave sine table of the odometry integrator.
package uoi_pkg;

  // Field widths
  localparam int LIN_W  = 16;
  localparam int ANG_W  = 24;
  localparam int DT_W   = 20;
  localparam int POS_W  = 48;
  localparam int HEAD_W = 32;
  localparam int TRIG_W = 16;

  // Sine table geometry: 2^SINE_STEPS_LOG2 steps per turn, a quarter wave stored
  localparam int SINE_STEPS_LOG2 = 13;
  localparam int TRIG_IDX_W      = SINE_STEPS_LOG2;
  localparam int QROM_AW         = SINE_STEPS_LOG2 - 1;
  localparam int QUARTER_LEN     = 1 << (SINE_STEPS_LOG2 - 2);
  localparam logic [TRIG_IDX_W-1:0] QUARTER_IDX  = TRIG_IDX_W'(QUARTER_LEN);
  localparam logic [QROM_AW-1:0]    QUARTER_ADDR = QROM_AW'(QUARTER_LEN);

  // Rounding offsets for the heading-to-index conversions
  localparam logic [HEAD_W-1:0] IDX_RND  = HEAD_W'(64'd1 << (31 - SINE_STEPS_LOG2));
  localparam logic [HEAD_W:0]   HIDX_RND = (HEAD_W + 1)'(64'd1 << (32 - SINE_STEPS_LOG2));

  // Shared multiplier: 32-bit signed by 21-bit signed
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = DT_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Position step: product in 2^-45 m, rounded to nearest at 2^-32 m
  localparam int STEP_SHIFT = 13;
  localparam int RND_W      = PROD_W + 1;
  localparam int STEP_W     = RND_W - STEP_SHIFT;
  localparam logic signed [RND_W-1:0] STEP_RND = RND_W'(64'd1 << (STEP_SHIFT - 1));

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic {
    CMD_VEL  = 1'b0,
    CMD_TICK = 1'b1
  } uoi_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_CS,
    ST_MUL_XD,
    ST_ADD_X,
    ST_MUL_YD,
    ST_ADD_Y,
    ST_YAW,
    ST_HALF_SIN,
    ST_HALF_COS,
    ST_OUT
  } uoi_state_e;

  typedef enum logic [1:0] {
    MA_SPEED,
    MA_PROD,
    MA_RATE
  } mul_a_sel_e;

  typedef enum logic {
    MB_TRIG,
    MB_DT
  } mul_b_sel_e;

  typedef enum logic {
    TRIG_SIN,
    TRIG_COS
  } trig_fn_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       vel_wr;
    logic       tick_ld;
    logic       trig_rd;
    trig_fn_e   trig_fn;
    logic       trig_half;
    logic       mul_en;
    mul_a_sel_e mul_a;
    mul_b_sel_e mul_b;
    logic       x_upd;
    logic       y_upd;
    logic       yaw_upd;
    logic       qz_ld;
    logic       out_ld;
  } uoi_cmd_t;

  // Table build, evaluated at elaboration only
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam int TAYLOR_TERMS = 13;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
  };

  typedef logic signed [TRIG_W-1:0] qrom_t [QUARTER_LEN+1];

  function automatic logic [63:0] mul_shift60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic qrom_t build_qrom();
    qrom_t       rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] t;
    for (int r = 0; r <= QUARTER_LEN; r++) begin
      x    = mul_shift60(PI_Q60, 64'(r) << (61 - SINE_STEPS_LOG2));
      x2   = mul_shift60(x, x);
      term = x;
      s    = x;
      // Taylor series with alternating signs, first correction subtracts
      for (int k = 0; k < TAYLOR_TERMS; k++) begin
        term = mul_shift60(term, x2) / TAYLOR_DIV[k];
        if ((k % 2) == 0) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
      t      = mul_shift60(s, 64'd65534);
      rom[r] = TRIG_W'((t + 64'd1) >> 1);
    end
    return rom;
  endfunction

  localparam qrom_t QROM = build_qrom();

endpackage

// ===== hdl/uoi_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
interface uoi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [uoi_pkg::LIN_W-1:0]    lin_vel;
  logic signed [uoi_pkg::ANG_W-1:0]    ang_vel;
  logic        [uoi_pkg::DT_W-1:0]     dt;

  modport source (output valid, output cmd, output lin_vel, output ang_vel, output dt,
                  input ready);
  modport sink (input valid, input cmd, input lin_vel, input ang_vel, input dt,
                output ready);
endinterface

interface uoi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [uoi_pkg::POS_W-1:0]    pos_x;
  logic signed [uoi_pkg::POS_W-1:0]    pos_y;
  logic        [uoi_pkg::HEAD_W-1:0]   heading;
  logic signed [uoi_pkg::TRIG_W-1:0]   quat_z;
  logic signed [uoi_pkg::TRIG_W-1:0]   quat_w;
  logic signed [uoi_pkg::LIN_W-1:0]    speed_out;
  logic signed [uoi_pkg::ANG_W-1:0]    turn_rate_out;
  logic                                saturated;

  modport source (output valid, output pos_x, output pos_y, output heading, output quat_z,
                  output quat_w, output speed_out, output turn_rate_out, output saturated,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading, input quat_z,
                input quat_w, input speed_out, input turn_rate_out, input saturated,
                output ready);
endinterface

// ===== hdl/uoi_trig.sv =====
// Sine/cosine lookup from the quarter-wave table with registered read.
module uoi_trig (
  input  logic                                clk_i,
  input  logic                                rd_i,
  input  uoi_pkg::trig_fn_e                   fn_i,
  input  logic [uoi_pkg::TRIG_IDX_W-1:0]      idx_i,
  output logic signed [uoi_pkg::TRIG_W-1:0]   val_o
);

  logic [uoi_pkg::TRIG_IDX_W-1:0]    ang;
  logic [1:0]                        quad;
  logic [uoi_pkg::QROM_AW-1:0]       ofs;
  logic [uoi_pkg::QROM_AW-1:0]       addr;
  logic signed [uoi_pkg::TRIG_W-1:0] mag;
  logic signed [uoi_pkg::TRIG_W-1:0] val_d;
  logic signed [uoi_pkg::TRIG_W-1:0] val_q;

  function automatic logic [uoi_pkg::TRIG_IDX_W-1:0] ang_sum(
      input logic [uoi_pkg::TRIG_IDX_W-1:0] a);
    return a + uoi_pkg::QUARTER_IDX;
  endfunction

  // Cosine is sine a quarter turn ahead; fold the quadrant onto the table
  always_comb begin
    ang   = (fn_i == uoi_pkg::TRIG_COS) ? ang_sum(idx_i) : idx_i;
    quad  = ang[uoi_pkg::TRIG_IDX_W-1 -: 2];
    ofs   = {1'b0, ang[uoi_pkg::TRIG_IDX_W-3:0]};
    addr  = quad[0] ? (uoi_pkg::QUARTER_ADDR - ofs) : ofs;
    mag   = uoi_pkg::QROM[addr];
    val_d = quad[1] ? -mag : mag;
  end

  always_ff @(posedge clk_i) begin
    if (rd_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

// ===== hdl/uoi_ctrl.sv =====
// Sequencer for the odometry integrator: accepts beats, steps the datapath, owns result valid.
module uoi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_cmd_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output uoi_pkg::uoi_cmd_t cmd_o
);

  uoi_pkg::uoi_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                is_tick;
  logic                out_free;

  assign in_ready_o  = (state_q == uoi_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_tick     = (in_cmd_i == uoi_pkg::CMD_TICK);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      uoi_pkg::ST_IDLE: begin
        if (accept && is_tick) begin
          state_d = uoi_pkg::ST_MUL_CS;
        end
      end
      uoi_pkg::ST_MUL_CS:   state_d = uoi_pkg::ST_MUL_XD;
      uoi_pkg::ST_MUL_XD:   state_d = uoi_pkg::ST_ADD_X;
      uoi_pkg::ST_ADD_X:    state_d = uoi_pkg::ST_MUL_YD;
      uoi_pkg::ST_MUL_YD:   state_d = uoi_pkg::ST_ADD_Y;
      uoi_pkg::ST_ADD_Y:    state_d = uoi_pkg::ST_YAW;
      uoi_pkg::ST_YAW:      state_d = uoi_pkg::ST_HALF_SIN;
      uoi_pkg::ST_HALF_SIN: state_d = uoi_pkg::ST_HALF_COS;
      uoi_pkg::ST_HALF_COS: state_d = uoi_pkg::ST_OUT;
      uoi_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = uoi_pkg::ST_IDLE;
        end
      end
      default: state_d = uoi_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.trig_fn   = uoi_pkg::TRIG_SIN;
    cmd_o.mul_a     = uoi_pkg::MA_SPEED;
    cmd_o.mul_b     = uoi_pkg::MB_TRIG;
    case (state_q)
      uoi_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.vel_wr  = !is_tick;
          cmd_o.tick_ld = is_tick;
          cmd_o.trig_rd = is_tick;
          cmd_o.trig_fn = uoi_pkg::TRIG_COS;
        end
      end
      uoi_pkg::ST_MUL_CS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.trig_rd = 1'b1;
      end
      uoi_pkg::ST_MUL_XD: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_a  = uoi_pkg::MA_PROD;
        cmd_o.mul_b  = uoi_pkg::MB_DT;
      end
      uoi_pkg::ST_ADD_X: begin
        cmd_o.x_upd  = 1'b1;
        cmd_o.mul_en = 1'b1;
      end
      uoi_pkg::ST_MUL_YD: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_a  = uoi_pkg::MA_PROD;
        cmd_o.mul_b  = uoi_pkg::MB_DT;
      end
      uoi_pkg::ST_ADD_Y: begin
        cmd_o.y_upd  = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_a  = uoi_pkg::MA_RATE;
        cmd_o.mul_b  = uoi_pkg::MB_DT;
      end
      uoi_pkg::ST_YAW: begin
        cmd_o.yaw_upd = 1'b1;
      end
      uoi_pkg::ST_HALF_SIN: begin
        cmd_o.trig_rd   = 1'b1;
        cmd_o.trig_half = 1'b1;
      end
      uoi_pkg::ST_HALF_COS: begin
        cmd_o.qz_ld     = 1'b1;
        cmd_o.trig_rd   = 1'b1;
        cmd_o.trig_half = 1'b1;
        cmd_o.trig_fn   = uoi_pkg::TRIG_COS;
      end
      uoi_pkg::ST_OUT: begin
        cmd_o.out_ld = out_free;
      end
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uoi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/uoi_dp.sv =====
// Datapath: pose state, shared multiplier, step rounding, saturating adder, result register.
module uoi_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  uoi_pkg::uoi_cmd_t                   cmd_i,
  input  logic signed [uoi_pkg::LIN_W-1:0]    lin_vel_i,
  input  logic signed [uoi_pkg::ANG_W-1:0]    ang_vel_i,
  input  logic        [uoi_pkg::DT_W-1:0]     dt_i,
  output logic signed [uoi_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [uoi_pkg::POS_W-1:0]    pos_y_o,
  output logic        [uoi_pkg::HEAD_W-1:0]   heading_o,
  output logic signed [uoi_pkg::TRIG_W-1:0]   quat_z_o,
  output logic signed [uoi_pkg::TRIG_W-1:0]   quat_w_o,
  output logic signed [uoi_pkg::LIN_W-1:0]    speed_out_o,
  output logic signed [uoi_pkg::ANG_W-1:0]    turn_rate_out_o,
  output logic                                saturated_o
);

  // Architectural state
  logic signed [uoi_pkg::POS_W-1:0]  x_q, y_q;
  logic        [uoi_pkg::HEAD_W-1:0] yaw_q;
  logic signed [uoi_pkg::LIN_W-1:0]  speed_q;
  logic signed [uoi_pkg::ANG_W-1:0]  rate_q;
  logic                              sat_q;

  // Working registers
  logic        [uoi_pkg::DT_W-1:0]   dt_q;
  logic signed [uoi_pkg::PROD_W-1:0] m_q;
  logic signed [uoi_pkg::TRIG_W-1:0] qz_q;

  // Result register
  logic signed [uoi_pkg::POS_W-1:0]  pos_x_q, pos_y_q;
  logic        [uoi_pkg::HEAD_W-1:0] heading_q;
  logic signed [uoi_pkg::TRIG_W-1:0] quat_z_q, quat_w_q;
  logic signed [uoi_pkg::LIN_W-1:0]  speed_out_q;
  logic signed [uoi_pkg::ANG_W-1:0]  turn_rate_out_q;
  logic                              saturated_q;

  logic        [uoi_pkg::HEAD_W-1:0]     idx_sum;
  logic        [uoi_pkg::HEAD_W:0]       hidx_sum;
  logic        [uoi_pkg::TRIG_IDX_W-1:0] trig_idx;
  logic signed [uoi_pkg::TRIG_W-1:0]     trig_val;

  logic signed [uoi_pkg::MUL_A_W-1:0] mul_a;
  logic signed [uoi_pkg::MUL_B_W-1:0] mul_b;
  logic signed [uoi_pkg::PROD_W-1:0]  prod;

  logic signed [uoi_pkg::RND_W-1:0]   rnd;
  logic signed [uoi_pkg::STEP_W-1:0]  step;
  logic signed [uoi_pkg::POS_W-1:0]   acc;
  logic signed [uoi_pkg::POS_W:0]     pos_sum;
  logic                               ovf;
  logic signed [uoi_pkg::POS_W-1:0]   pos_new;

  // Table index of the heading and of half the heading, both rounded to nearest
  assign idx_sum  = yaw_q + uoi_pkg::IDX_RND;
  assign hidx_sum = {1'b0, yaw_q} + uoi_pkg::HIDX_RND;
  assign trig_idx = cmd_i.trig_half
                  ? hidx_sum[uoi_pkg::HEAD_W -: uoi_pkg::TRIG_IDX_W]
                  : idx_sum[uoi_pkg::HEAD_W-1 -: uoi_pkg::TRIG_IDX_W];

  uoi_trig u_trig (
    .clk_i (clk_i),
    .rd_i  (cmd_i.trig_rd),
    .fn_i  (cmd_i.trig_fn),
    .idx_i (trig_idx),
    .val_o (trig_val)
  );

  // Shared multiplier operand selection
  always_comb begin
    case (cmd_i.mul_a)
      uoi_pkg::MA_SPEED: mul_a = {{(uoi_pkg::MUL_A_W-uoi_pkg::LIN_W){speed_q[uoi_pkg::LIN_W-1]}},
                                  speed_q};
      uoi_pkg::MA_PROD:  mul_a = m_q[uoi_pkg::MUL_A_W-1:0];
      uoi_pkg::MA_RATE:  mul_a = {{(uoi_pkg::MUL_A_W-uoi_pkg::ANG_W){rate_q[uoi_pkg::ANG_W-1]}},
                                  rate_q};
      default:           mul_a = '0;
    endcase
    case (cmd_i.mul_b)
      uoi_pkg::MB_TRIG: mul_b = {{(uoi_pkg::MUL_B_W-uoi_pkg::TRIG_W){trig_val[uoi_pkg::TRIG_W-1]}},
                                 trig_val};
      uoi_pkg::MB_DT:   mul_b = {1'b0, dt_q};
      default:          mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Round the step to nearest, ties up, then add with saturation
  always_comb begin
    rnd     = {m_q[uoi_pkg::PROD_W-1], m_q} + uoi_pkg::STEP_RND;
    step    = rnd[uoi_pkg::RND_W-1:uoi_pkg::STEP_SHIFT];
    acc     = cmd_i.y_upd ? y_q : x_q;
    pos_sum = {acc[uoi_pkg::POS_W-1], acc}
            + {{(uoi_pkg::POS_W+1-uoi_pkg::STEP_W){step[uoi_pkg::STEP_W-1]}}, step};
    ovf     = pos_sum[uoi_pkg::POS_W] != pos_sum[uoi_pkg::POS_W-1];
    if (ovf) begin
      pos_new = pos_sum[uoi_pkg::POS_W] ? uoi_pkg::POS_MIN : uoi_pkg::POS_MAX;
    end else begin
      pos_new = pos_sum[uoi_pkg::POS_W-1:0];
    end
  end

  // Pose and speed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      y_q     <= '0;
      yaw_q   <= '0;
      speed_q <= '0;
      rate_q  <= '0;
      sat_q   <= 1'b0;
    end else begin
      if (cmd_i.vel_wr) begin
        speed_q <= lin_vel_i;
        rate_q  <= ang_vel_i;
      end
      if (cmd_i.x_upd) begin
        x_q <= pos_new;
      end
      if (cmd_i.y_upd) begin
        y_q <= pos_new;
      end
      if (cmd_i.yaw_upd) begin
        yaw_q <= yaw_q + m_q[uoi_pkg::HEAD_W-1:0];
      end
      if (cmd_i.tick_ld) begin
        sat_q <= 1'b0;
      end else if (cmd_i.x_upd || cmd_i.y_upd) begin
        sat_q <= sat_q | ovf;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_ld) begin
      dt_q <= dt_i;
    end
    if (cmd_i.mul_en) begin
      m_q <= prod;
    end
    if (cmd_i.qz_ld) begin
      qz_q <= trig_val;
    end
    if (cmd_i.out_ld) begin
      pos_x_q         <= x_q;
      pos_y_q         <= y_q;
      heading_q       <= yaw_q;
      quat_z_q        <= qz_q;
      quat_w_q        <= trig_val;
      speed_out_q     <= speed_q;
      turn_rate_out_q <= rate_q;
      saturated_q     <= sat_q;
    end
  end

  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign heading_o       = heading_q;
  assign quat_z_o        = quat_z_q;
  assign quat_w_o        = quat_w_q;
  assign speed_out_o     = speed_out_q;
  assign turn_rate_out_o = turn_rate_out_q;
  assign saturated_o     = saturated_q;

endmodule

// ===== hdl/unicycle_odometry_integrator_unit.sv =====
// Top level of the unicycle dead-reckoning odometry integrator.
//
// in_i carries input beats: cmd 0 latches lin_vel and ang_vel and produces no
// result; cmd 1 carries dt and advances the pose by one tick.
// out_o carries one result beat per tick: saturating x/y position, wrapping
// heading, yaw quaternion (z, w) of the new heading, the latched speeds and a
// flag that is set when a position clipped on that tick.
// A velocity beat leaves ready high; the next beat may follow right away.
// A tick keeps ready low until its last step has loaded the result register; the
// next beat and the tick's result can then both be taken in the same cycle. The
// tick's length is set by the single shared 32x21 multiplier (five products per
// tick) and the one-read-a-cycle sine table (four lookups per tick).
// The result sits in an output register, so new beats are accepted while it
// waits; a tick only stalls in its last step if the previous result has not
// been taken yet.
// Reset clears position, heading and the latched speeds to zero and drops
// out_o.valid.
module unicycle_odometry_integrator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  uoi_in_if.sink    in_i,
  uoi_out_if.source out_o
);

  uoi_pkg::uoi_cmd_t dp_cmd;

  uoi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (dp_cmd)
  );

  uoi_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .lin_vel_i       (in_i.lin_vel),
    .ang_vel_i       (in_i.ang_vel),
    .dt_i            (in_i.dt),
    .pos_x_o         (out_o.pos_x),
    .pos_y_o         (out_o.pos_y),
    .heading_o       (out_o.heading),
    .quat_z_o        (out_o.quat_z),
    .quat_w_o        (out_o.quat_w),
    .speed_out_o     (out_o.speed_out),
    .turn_rate_out_o (out_o.turn_rate_out),
    .saturated_o     (out_o.saturated)
  );

  // A velocity beat never holds off the next beat
  a_vel_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !in_i.cmd) |=> in_i.ready)
    else $error("ready dropped after a velocity beat");

  // A tick occupies the sequencer
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.cmd) |=> !in_i.ready)
    else $error("ready held after a tick beat");

  // Table values are symmetric, so the most negative code never appears
  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.quat_z != 16'h8000 && out_o.quat_w != 16'h8000))
    else $error("quaternion component out of table range");

endmodule
